@@ rtl/ils_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Sizes, operation and status codes, sequencer states and the structs passed
// between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ils_pkg;

    // storage geometry
    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // field widths of a request and a result word
    localparam int OP_BITS  = 3;
    localparam int POS_BITS = 9;
    localparam int ST_BITS  = 2;

    localparam int IN_FIELD_BITS   = OP_BITS + POS_BITS + WORD_BITS;
    localparam int IN_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS  = WORD_BITS + ST_BITS + CNT_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // bit positions inside the result tdata
    localparam int OUT_ST_LSB  = WORD_BITS;
    localparam int OUT_LEN_LSB = WORD_BITS + ST_BITS;

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    // operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_READ    = 3'd2;
    localparam logic [OP_BITS-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_REPLACE = 3'd4;
    localparam logic [OP_BITS-1:0] OP_CLEAR   = 3'd5;

    // status codes
    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_BITS-1:0] ST_BAD   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [POS_BITS-1:0]  position;
        logic [OP_BITS-1:0]   opcode;
    } t_cmd;

    typedef struct packed {
        logic [CNT_BITS-1:0]  length;
        logic [ST_BITS-1:0]   status;
        logic [WORD_BITS-1:0] word;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [ADDR_BITS-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

@@ rtl/ils_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/ils_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ctrl: list sequencer
// Holds the word count, decodes a request and walks the memory for shifts.
// ----------------------------------------------------------------------------
module ils_ctrl
    import ils_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_valid,
    input  wire t_cmd                 i_cmd,
    input  wire logic [WORD_BITS-1:0] i_rdata,
    output logic                      o_idle,
    output logic                      o_done,
    output t_result                   o_res,
    output t_ram_req                  o_ram
);

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  r_ins,   n_ins;
    logic                  r_pend,  n_pend;
    logic [ADDR_BITS-1:0]  r_ptr,   n_ptr;
    logic [ADDR_BITS-1:0]  r_end,   n_end;
    logic [ADDR_BITS-1:0]  r_wa,    n_wa;
    logic [ADDR_BITS-1:0]  r_pos,   n_pos;
    logic [WORD_BITS-1:0]  r_word,  n_word;

    // request decode
    logic [POS_BITS-1:0]   w_cnt_pos;
    logic [POS_BITS-1:0]   w_cnt_m1_pos;
    logic [ADDR_BITS-1:0]  w_pos_addr;
    logic [ADDR_BITS-1:0]  w_cnt_addr;
    logic [ADDR_BITS-1:0]  w_cnt_m1_addr;
    logic                  w_full;
    logic [ST_BITS-1:0]    w_st;
    logic                  w_imm_done;
    logic                  w_imm_we;
    logic [ADDR_BITS-1:0]  w_imm_waddr;
    logic                  w_go_shift;
    logic                  w_go_read;
    logic [CNT_BITS-1:0]   w_imm_cnt;

    assign w_cnt_pos     = POS_BITS'(r_count);
    assign w_cnt_m1_pos  = POS_BITS'(r_count - 1'b1);
    assign w_pos_addr    = i_cmd.position[ADDR_BITS-1:0];
    assign w_cnt_addr    = r_count[ADDR_BITS-1:0];
    assign w_cnt_m1_addr = w_cnt_m1_pos[ADDR_BITS-1:0];
    assign w_full        = (r_count == FULL_COUNT);

    always_comb begin
        w_st        = ST_OK;
        w_imm_done  = 1'b1;
        w_imm_we    = 1'b0;
        w_imm_waddr = w_pos_addr;
        w_go_shift  = 1'b0;
        w_go_read   = 1'b0;
        w_imm_cnt   = r_count;
        case (i_cmd.opcode)
            OP_INSERT: begin
                if (i_cmd.position > w_cnt_pos) begin
                    w_st = ST_RANGE;
                end else if (w_full) begin
                    w_st = ST_FULL;
                end else if (i_cmd.position == w_cnt_pos) begin
                    // insert at the tail needs no shift
                    w_imm_we  = 1'b1;
                    w_imm_cnt = r_count + 1'b1;
                end else begin
                    w_imm_done = 1'b0;
                    w_go_shift = 1'b1;
                end
            end
            OP_APPEND: begin
                if (w_full) begin
                    w_st = ST_FULL;
                end else begin
                    w_imm_we    = 1'b1;
                    w_imm_waddr = w_cnt_addr;
                    w_imm_cnt   = r_count + 1'b1;
                end
            end
            OP_READ: begin
                if (i_cmd.position >= w_cnt_pos) begin
                    w_st = ST_RANGE;
                end else begin
                    w_imm_done = 1'b0;
                    w_go_read  = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (i_cmd.position >= w_cnt_pos) begin
                    w_st = ST_RANGE;
                end else if (i_cmd.position == w_cnt_m1_pos) begin
                    // dropping the last word moves nothing
                    w_imm_cnt = r_count - 1'b1;
                end else begin
                    w_imm_done = 1'b0;
                    w_go_shift = 1'b1;
                end
            end
            OP_REPLACE: begin
                if (i_cmd.position >= w_cnt_pos) begin
                    w_st = ST_RANGE;
                end else begin
                    w_imm_we = 1'b1;
                end
            end
            OP_CLEAR: begin
                w_imm_cnt = '0;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ins   = r_ins;
        n_pend  = r_pend;
        n_ptr   = r_ptr;
        n_end   = r_end;
        n_wa    = r_wa;
        n_pos   = r_pos;
        n_word  = r_word;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_count = w_imm_cnt;
                    n_ins   = (i_cmd.opcode == OP_INSERT);
                    n_pos   = w_pos_addr;
                    n_word  = i_cmd.word;
                    n_pend  = 1'b0;
                    if (i_cmd.opcode == OP_INSERT) begin
                        // walk down from the last word to the insert point
                        n_ptr = w_cnt_m1_addr;
                        n_end = w_pos_addr;
                    end else begin
                        // walk up from the word after the hole to the last word
                        n_ptr = w_pos_addr + 1'b1;
                        n_end = w_cnt_m1_addr;
                    end
                    if (w_go_shift) begin
                        n_state = S_SHIFT;
                    end else if (w_go_read) begin
                        n_state = S_RDWAIT;
                    end
                end
            end
            S_SHIFT: begin
                n_pend = 1'b1;
                n_wa   = r_ins ? r_ptr + 1'b1 : r_ptr - 1'b1;
                if (r_ptr == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ins ? r_ptr - 1'b1 : r_ptr + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_ins) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_IDLE;
                    n_count = r_count - 1'b1;
                end
            end
            S_PUT: begin
                n_state = S_IDLE;
                n_count = r_count + 1'b1;
            end
            S_RDWAIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ram.we     = 1'b0;
        o_ram.waddr  = r_wa;
        o_ram.wdata  = i_rdata;
        o_ram.raddr  = r_ptr;
        o_done       = 1'b0;
        o_res.word   = '0;
        o_res.status = ST_OK;
        o_res.length = n_count;
        case (r_state)
            S_IDLE: begin
                o_ram.raddr = w_pos_addr;
                if (i_cmd_valid) begin
                    o_ram.we     = w_imm_we;
                    o_ram.waddr  = w_imm_waddr;
                    o_ram.wdata  = i_cmd.word;
                    o_done       = w_imm_done;
                    o_res.status = w_st;
                end
            end
            S_SHIFT: begin
                o_ram.we = r_pend;
            end
            S_DRAIN: begin
                o_ram.we = 1'b1;
                o_done   = !r_ins;
            end
            S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_pos;
                o_ram.wdata = r_word;
                o_done      = 1'b1;
            end
            S_RDWAIT: begin
                o_done     = 1'b1;
                o_res.word = i_rdata;
            end
            default: begin
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins  <= n_ins;
        r_ptr  <= n_ptr;
        r_end  <= n_end;
        r_wa   <= n_wa;
        r_pos  <= n_pos;
        r_word <= n_word;
    end

endmodule
`default_nettype wire

@@ rtl/indexed_list_store.sv @@
// Completion: append, replace, clear, tail insert, last-word remove and every rejected
//   request finish at the accepting edge; a read passes through S_RDWAIT; an insert
//   walks S_SHIFT per moved word, then S_DRAIN and S_PUT; a remove S_SHIFT, S_DRAIN.
// Flow: one request at a time; a new request is taken once the sequencer is idle
//   and the last result word leaves.
// Reset clears the word count and the result valid flag; memory is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store: ordered word list with insert and remove at an index
// Requests arrive on the slave stream, one result word per request leaves on
// the master stream. Words live in a single memory; shifts run as a
// read-ahead, write-behind walk through it.
// ----------------------------------------------------------------------------
module indexed_list_store
    import ils_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // [2:0] opcode, [11:3] position, [43:12] word_in, [47:44] zero
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // result stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [31:0] word_out, [33:32] status, [42:34] length, [47:43] zero
    output logic      [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    t_cmd                 w_cmd;
    logic                 w_accept;
    logic                 w_idle;
    logic                 w_done;
    t_result              w_res;
    t_ram_req             w_ram;
    logic [WORD_BITS-1:0] w_rdata;

    logic                 r_out_valid;
    t_result              r_out;

    assign w_cmd = t_cmd'(s_axis_tdata[IN_FIELD_BITS-1:0]);

    // Take a request only while the sequencer is idle and the output register
    // is empty or being emptied this cycle: every request finishing at the
    // accepting edge lands in the output register at that same edge.
    assign s_axis_tready = w_idle && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ils_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_accept),
        .i_cmd       (w_cmd),
        .i_rdata     (w_rdata),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_res       (w_res),
        .o_ram       (w_ram)
    );

    ils_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // Output register: load on completion, drop once the sink takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload until the next completion.
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'(r_out);

endmodule
`default_nettype wire

@@ rtl/ils_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed list store
// Watches the stream ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
module ils_checker
    import ils_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    logic [WORD_BITS-1:0] w_word;
    logic [ST_BITS-1:0]   w_st;
    logic [CNT_BITS-1:0]  w_len;

    assign w_word = m_axis_tdata[WORD_BITS-1:0];
    assign w_st   = m_axis_tdata[OUT_ST_LSB +: ST_BITS];
    assign w_len  = m_axis_tdata[OUT_LEN_LSB +: CNT_BITS];

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // the list never reports more words than it can store
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_len <= FULL_COUNT)
        else $error("length beyond depth");

    // only defined status codes, and a failed request returns no data
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_st != ST_BAD)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_st != ST_OK |-> w_word == '0)
        else $error("failed request returned data");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);
`default_nettype wire
